// ----- rtl/bcva_pkg.sv -----
package bcva_pkg;

  // converter and field widths
  localparam int ADC_BITS      = 12;
  localparam int CODE_W        = 12;
  localparam int SCALE_W       = 24;
  localparam int BIAS_W        = 12;
  localparam int CELLS_W       = 4;
  localparam int MV_W          = 13;
  localparam int FRAC_BITS     = 8;
  localparam int AVG_W         = MV_W + FRAC_BITS;
  localparam int LEVELS        = 3;
  localparam int LOW_LVL_W     = 4;
  localparam int VLOW_LVL_W    = 6;

  // configuration port
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 24;

  // pack voltage path
  localparam int PROD_W        = CODE_W + SCALE_W;
  localparam int SCALE_FRAC    = 16;
  localparam int MVR_W         = PROD_W + 1 - SCALE_FRAC;
  localparam int SUM_W         = MVR_W + 2;
  localparam int PACK_W        = 16;

  // shared divider
  localparam int DIVIDEND_W    = AVG_W + 4;
  localparam int DIVISOR_W     = 4;
  localparam int DIV_STEPS     = DIVIDEND_W;
  localparam int DIV_CNT_W     = $clog2(DIV_STEPS + 1);

  // persistence
  localparam int PERSIST_TICKS = 20;
  localparam int CNT_W         = $clog2(PERSIST_TICKS + 1);

  localparam logic [CODE_W-1:0]     ADC_MASK     = CODE_W'((64'd1 << ADC_BITS) - 64'd1);
  localparam logic [PROD_W:0]       ROUND_HALF   = (PROD_W+1)'(64'd1 << (SCALE_FRAC - 1));
  localparam logic [AVG_W-1:0]      AVG_MAX      = {AVG_W{1'b1}};
  localparam logic [DIVISOR_W-1:0]  FILT_DIVISOR = DIVISOR_W'(11);
  localparam logic [DIVIDEND_W-1:0] FILT_ROUND   = DIVIDEND_W'(5);
  localparam logic [LOW_LVL_W-1:0]  LOW_LEVEL    = LOW_LVL_W'(10);
  localparam logic [VLOW_LVL_W-1:0] VLOW_LEVEL   = VLOW_LVL_W'(50);

  // register reset values
  localparam logic [SCALE_W-1:0]    SCALE_RST    = SCALE_W'(403000);
  localparam logic [BIAS_W-1:0]     BIAS_RST     = '0;
  localparam logic [CELLS_W-1:0]    CELLS_RST    = CELLS_W'(3);
  localparam logic [MV_W-1:0]       LOW_RST      = MV_W'(3500);
  localparam logic [MV_W-1:0]       VLOW_RST     = MV_W'(3400);
  localparam logic [MV_W-1:0]       MAXLOW_RST   = MV_W'(3200);

  // level slots
  localparam int LVL_LOW    = 0;
  localparam int LVL_VLOW   = 1;
  localparam int LVL_MAXLOW = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE  = 3'd0,
    CFG_BIAS   = 3'd1,
    CFG_CELLS  = 3'd2,
    CFG_LOW    = 3'd3,
    CFG_VLOW   = 3'd4,
    CFG_MAXLOW = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_PACK,
    S_CDIV,
    S_CWAIT,
    S_CHECK,
    S_FDIV,
    S_FWAIT,
    S_UPD
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic commit;
    logic filter_on;
    logic armed;
  } alarm_ctl_t;

  typedef struct packed {
    logic [LEVELS-1:0] latch;
    logic              beeper;
    logic [LEVELS-1:0] fire;
  } alarm_stat_t;

endpackage

// ----- rtl/bcva_if.sv -----
interface bcva_in_if;
  import bcva_pkg::*;

  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] adc_code;
  logic              armed_now;

  modport source (output valid, output adc_code, output armed_now, input ready);
  modport sink   (input valid, input adc_code, input armed_now, output ready);
endinterface

interface bcva_out_if;
  import bcva_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [MV_W-1:0]       avg_cell_mv;
  logic [LOW_LVL_W-1:0]  low_warn_level;
  logic [VLOW_LVL_W-1:0] very_low_warn_level;
  logic                  low_latched;
  logic                  very_low_latched;
  logic                  max_low_latched;
  logic                  beeper_on;
  logic                  low_event;
  logic                  very_low_event;
  logic                  max_low_event;

  modport source (
    output valid, output avg_cell_mv, output low_warn_level, output very_low_warn_level,
    output low_latched, output very_low_latched, output max_low_latched,
    output beeper_on, output low_event, output very_low_event, output max_low_event,
    input ready
  );
  modport sink (
    input valid, input avg_cell_mv, input low_warn_level, input very_low_warn_level,
    input low_latched, input very_low_latched, input max_low_latched,
    input beeper_on, input low_event, input very_low_event, input max_low_event,
    output ready
  );
endinterface

// ----- rtl/bcva_div.sv -----
module bcva_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [bcva_pkg::DIVIDEND_W-1:0]    dividend,
  input  logic [bcva_pkg::DIVISOR_W-1:0]     divisor,
  output logic [bcva_pkg::DIVIDEND_W-1:0]    quotient,
  output bcva_pkg::div_stat_t                stat
);
  import bcva_pkg::*;

  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVISOR_W-1:0]  dsr_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic                  busy_r;
  logic                  done_r;

  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial = {rem_r, quo_r[DIVIDEND_W-1]};
    diff  = trial - {1'b0, dsr_r};
    ge    = (trial >= {1'b0, dsr_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= DIV_CNT_W'(DIV_STEPS);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIVIDEND_W-2:0], ge};
      rem_r <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

`ifndef SYNTHESIS
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r)
    else $error("divider did not start");
`endif

endmodule

// ----- rtl/bcva_alarm.sv -----
module bcva_alarm (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  bcva_pkg::alarm_ctl_t                          ctl,
  input  logic [bcva_pkg::AVG_W-1:0]                    avg,
  input  logic [bcva_pkg::LEVELS-1:0][bcva_pkg::MV_W-1:0] thr,
  output bcva_pkg::alarm_stat_t                         stat
);
  import bcva_pkg::*;

  logic [CNT_W-1:0]  cnt_r   [LEVELS];
  logic [CNT_W-1:0]  cnt_nxt [LEVELS];
  logic [LEVELS-1:0] latch_r;
  logic [LEVELS-1:0] latch_nxt;
  logic [LEVELS-1:0] fire;
  logic              beeper_r;
  logic              beeper_nxt;
  logic              prev_armed_r;
  logic              fell;

  always_comb begin
    for (int i = 0; i < LEVELS; i++) begin
      cnt_nxt[i] = cnt_r[i];
      fire[i]    = 1'b0;
      if (ctl.filter_on) begin
        if (avg < {thr[i], {FRAC_BITS{1'b0}}}) begin
          if (cnt_r[i] < CNT_W'(PERSIST_TICKS)) begin
            cnt_nxt[i] = cnt_r[i] + 1'b1;
            fire[i]    = (cnt_nxt[i] == CNT_W'(PERSIST_TICKS)) && !latch_r[i];
          end
        end else if (cnt_r[i] != '0) begin
          cnt_nxt[i] = cnt_r[i] - 1'b1;
        end
      end
    end
    // disarm clears after any firing in the same tick
    fell       = !ctl.armed && prev_armed_r;
    latch_nxt  = (latch_r | fire) & {LEVELS{!fell}};
    beeper_nxt = (beeper_r | fire[LVL_MAXLOW]) & !fell;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LEVELS; i++) begin
        cnt_r[i] <= '0;
      end
      latch_r      <= '0;
      beeper_r     <= 1'b0;
      prev_armed_r <= 1'b0;
    end else if (ctl.commit) begin
      for (int i = 0; i < LEVELS; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
      latch_r      <= latch_nxt;
      beeper_r     <= beeper_nxt;
      prev_armed_r <= ctl.armed;
    end
  end

  assign stat.latch  = latch_nxt;
  assign stat.beeper = beeper_nxt;
  assign stat.fire   = fire;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r[0] <= CNT_W'(PERSIST_TICKS)) && (cnt_r[1] <= CNT_W'(PERSIST_TICKS)) &&
    (cnt_r[2] <= CNT_W'(PERSIST_TICKS)))
    else $error("persistence count beyond limit");
  a_beeper_latch: assert property (@(posedge clk) disable iff (!rst_n)
    beeper_r == latch_r[LVL_MAXLOW])
    else $error("beeper out of step with lowest latch");
`endif

endmodule

// ----- rtl/battery_cell_voltage_alarm.sv -----
// Battery cell voltage alarm.
// Input channel in_ch carries one tick: adc_code and armed_now. Result
// channel out_ch returns exactly one result per tick: the filtered cell
// voltage in millivolts, the three warning latches, the beeper and the
// events that fired on that tick. Both use valid/ready; an item moves on
// a clock edge with both high. Registers are written through cfg_we,
// cfg_index and cfg_wdata; the user must do so only while the block is
// idle, as the block does not enforce it. Indexes 6 and 7 are ignored.
// Timing: an item takes longer from accept to out_ch.valid once a
// battery has been detected than before. The time is set by the
// shared restoring divider, which produces one quotient bit per cycle
// and runs twice per tick once a battery has been detected, for the
// per-cell split and for the average step, and once before that. A new
// item is taken only after the result is loaded into the output register.
// When the receiver stalls, the finished result waits in the output
// register and the next item can be accepted and processed; its result is
// held back until the output register frees up.
// Synchronous reset (rst_n low) restores the register defaults, clears the
// average, detection, counters, latches and beeper, and empties out_ch.
module battery_cell_voltage_alarm (
  input  logic                              clk,
  input  logic                              rst_n,
  bcva_in_if.sink                           in_ch,
  bcva_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [bcva_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bcva_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import bcva_pkg::*;

  // configuration
  logic [SCALE_W-1:0]            scale_r;
  logic [BIAS_W-1:0]             bias_r;
  logic [CELLS_W-1:0]            cells_r;
  logic [LEVELS-1:0][MV_W-1:0]   thr_r;

  // sequencer and datapath
  state_t                        state_r;
  state_t                        state_nxt;
  logic [CODE_W-1:0]             code_r;
  logic                          armed_r;
  logic [PROD_W-1:0]             prod_r;
  logic [PACK_W-1:0]             pack_r;
  logic [AVG_W-1:0]              v_r;
  logic [AVG_W-1:0]              avg_r;
  logic                          present_r;
  logic                          filter_on_r;

  // output register
  logic                          out_valid_r;
  logic [MV_W-1:0]               out_avg_r;
  logic [LEVELS-1:0]             out_latch_r;
  logic                          out_beeper_r;
  logic [LEVELS-1:0]             out_fire_r;

  logic                          room;
  logic                          commit;
  logic                          div_start;
  logic [DIVIDEND_W-1:0]         div_dividend;
  logic [DIVISOR_W-1:0]          div_divisor;
  logic [DIVIDEND_W-1:0]         div_quo;
  div_stat_t                     div_stat;
  alarm_ctl_t                    alarm_ctl;
  alarm_stat_t                   alarm_stat;

  logic [PROD_W:0]               rnd_sum;
  logic [SUM_W-1:0]              mv_sum;
  logic [PACK_W-1:0]             pack_sat;
  logic [CELLS_W-1:0]            cells_eff;
  logic [AVG_W-1:0]              v_sat;
  logic [DIVIDEND_W-1:0]         base_ext;
  logic [DIVIDEND_W-1:0]         filt_num;
  logic                          detect;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RST;
      bias_r  <= BIAS_RST;
      cells_r <= CELLS_RST;
      thr_r[LVL_LOW]    <= LOW_RST;
      thr_r[LVL_VLOW]   <= VLOW_RST;
      thr_r[LVL_MAXLOW] <= MAXLOW_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SCALE:  scale_r <= cfg_wdata[SCALE_W-1:0];
        CFG_BIAS:   bias_r  <= cfg_wdata[BIAS_W-1:0];
        CFG_CELLS:  cells_r <= cfg_wdata[CELLS_W-1:0];
        CFG_LOW:    thr_r[LVL_LOW]    <= cfg_wdata[MV_W-1:0];
        CFG_VLOW:   thr_r[LVL_VLOW]   <= cfg_wdata[MV_W-1:0];
        CFG_MAXLOW: thr_r[LVL_MAXLOW] <= cfg_wdata[MV_W-1:0];
        default: ;
      endcase
    end
  end

  // pack millivolts: round, add bias, clamp to 0..65535
  always_comb begin
    rnd_sum = {1'b0, prod_r} + ROUND_HALF;
    mv_sum  = {2'b00, rnd_sum[PROD_W:SCALE_FRAC]} +
              {{(SUM_W-BIAS_W){bias_r[BIAS_W-1]}}, bias_r};
    if (mv_sum[SUM_W-1]) begin
      pack_sat = '0;
    end else if (|mv_sum[SUM_W-2:PACK_W]) begin
      pack_sat = {PACK_W{1'b1}};
    end else begin
      pack_sat = mv_sum[PACK_W-1:0];
    end
  end

  always_comb begin
    cells_eff = (cells_r == '0) ? CELLS_W'(1) : cells_r;
    v_sat     = (|div_quo[DIVIDEND_W-1:AVG_W]) ? AVG_MAX : div_quo[AVG_W-1:0];
    detect    = present_r || (v_r > {thr_r[LVL_MAXLOW], {FRAC_BITS{1'b0}}});
    // first detection seeds the average with the sample
    base_ext  = {{(DIVIDEND_W-AVG_W){1'b0}}, (present_r ? avg_r : v_r)};
    filt_num  = (base_ext << 3) + (base_ext << 1) +
                {{(DIVIDEND_W-AVG_W){1'b0}}, v_r} + FILT_ROUND;
  end

  assign room = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_ch.valid) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_PACK;
      S_PACK:  state_nxt = S_CDIV;
      S_CDIV:  state_nxt = S_CWAIT;
      S_CWAIT: if (div_stat.done) state_nxt = S_CHECK;
      S_CHECK: state_nxt = detect ? S_FDIV : S_UPD;
      S_FDIV:  state_nxt = S_FWAIT;
      S_FWAIT: if (div_stat.done) state_nxt = S_UPD;
      S_UPD:   if (room) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = {1'b0, pack_r, {FRAC_BITS{1'b0}}};
    div_divisor  = cells_eff;
    commit       = 1'b0;
    unique case (state_r)
      S_CDIV: div_start = 1'b1;
      S_FDIV: begin
        div_start    = 1'b1;
        div_dividend = filt_num;
        div_divisor  = FILT_DIVISOR;
      end
      S_UPD:  commit = room;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      present_r   <= 1'b0;
      avg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_FWAIT && div_stat.done) begin
        avg_r     <= div_quo[AVG_W-1:0];
        present_r <= 1'b1;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_ch.valid) begin
      code_r  <= in_ch.adc_code & ADC_MASK;
      armed_r <= in_ch.armed_now;
    end
    if (state_r == S_MUL) begin
      prod_r <= PROD_W'(code_r) * PROD_W'(scale_r);
    end
    if (state_r == S_PACK) begin
      pack_r <= pack_sat;
    end
    if (state_r == S_CWAIT && div_stat.done) begin
      v_r <= v_sat;
    end
    if (state_r == S_CHECK) begin
      filter_on_r <= detect;
    end
    if (commit) begin
      out_avg_r    <= avg_r[AVG_W-1:FRAC_BITS];
      out_latch_r  <= alarm_stat.latch;
      out_beeper_r <= alarm_stat.beeper;
      out_fire_r   <= alarm_stat.fire;
    end
  end

  assign alarm_ctl.commit    = commit;
  assign alarm_ctl.filter_on = filter_on_r;
  assign alarm_ctl.armed     = armed_r;

  bcva_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  bcva_alarm u_alarm (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (alarm_ctl),
    .avg   (avg_r),
    .thr   (thr_r),
    .stat  (alarm_stat)
  );

  assign in_ch.ready                = (state_r == S_IDLE);
  assign out_ch.valid               = out_valid_r;
  assign out_ch.avg_cell_mv         = out_avg_r;
  assign out_ch.low_warn_level      = out_latch_r[LVL_LOW] ? LOW_LEVEL : '0;
  assign out_ch.very_low_warn_level = out_latch_r[LVL_VLOW] ? VLOW_LEVEL : '0;
  assign out_ch.low_latched         = out_latch_r[LVL_LOW];
  assign out_ch.very_low_latched    = out_latch_r[LVL_VLOW];
  assign out_ch.max_low_latched     = out_latch_r[LVL_MAXLOW];
  assign out_ch.beeper_on           = out_beeper_r;
  assign out_ch.low_event           = out_fire_r[LVL_LOW];
  assign out_ch.very_low_event      = out_fire_r[LVL_VLOW];
  assign out_ch.max_low_event       = out_fire_r[LVL_MAXLOW];

`ifndef SYNTHESIS
  a_accept_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == S_MUL))
    else $error("accepted item did not start");
  a_avg_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !present_r |-> (avg_r == '0))
    else $error("average moved before detection");
`endif

endmodule

// ----- test/tb_battery_cell_voltage_alarm.sv -----
`timescale 1ns / 100ps

module tb_battery_cell_voltage_alarm;
  import bcva_pkg::*;

  typedef struct packed {
    logic [MV_W-1:0]       avg_cell_mv;
    logic [LOW_LVL_W-1:0]  low_warn_level;
    logic [VLOW_LVL_W-1:0] very_low_warn_level;
    logic                  low_latched;
    logic                  very_low_latched;
    logic                  max_low_latched;
    logic                  beeper_on;
    logic                  low_event;
    logic                  very_low_event;
    logic                  max_low_event;
  } alarm_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CODE_W-1:0]     code;
    logic                  armed;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    bit                    typed;
    alarm_result_t         want;
  } stim_row_t;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(6);
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 250;
  localparam int DRAIN_CYCLES  = 120;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bcva_in_if  in_if ();
  bcva_out_if out_if ();

  battery_cell_voltage_alarm u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor copy of registers and state
  logic [SCALE_W-1:0] m_scale;
  logic [BIAS_W-1:0]  m_bias;
  logic [CELLS_W-1:0] m_cells;
  logic [MV_W-1:0]    m_thr [LEVELS];
  bit                 m_present;
  longint             m_avg;
  int                 m_cnt [LEVELS];
  logic [LEVELS-1:0]  m_latch;
  bit                 m_beeper;
  bit                 m_prev_armed;

  alarm_result_t pending_results [$];
  stim_row_t     stim_table [$];
  int            mismatch_count = 0;
  int            results_seen = 0;
  bit            src_calm = 1'b0;
  bit            sink_calm = 1'b0;
  bit            in_hot = 1'b0;
  int            stall_left = 0;

  task automatic alarm_reset();
    m_scale      = SCALE_RST;
    m_bias       = BIAS_RST;
    m_cells      = CELLS_RST;
    m_thr[LVL_LOW]    = LOW_RST;
    m_thr[LVL_VLOW]   = VLOW_RST;
    m_thr[LVL_MAXLOW] = MAXLOW_RST;
    m_present    = 1'b0;
    m_avg        = 0;
    m_latch      = '0;
    m_beeper     = 1'b0;
    m_prev_armed = 1'b0;
    foreach (m_cnt[i]) m_cnt[i] = 0;
  endtask

  function automatic alarm_result_t alarm_step(logic [CODE_W-1:0] code_in, logic armed);
    longint code, mv, cells, v;
    logic [LEVELS-1:0] fire;
    alarm_result_t r;
    fire  = '0;
    code  = longint'(code_in & ADC_MASK);
    mv    = (code * longint'(m_scale) + 32768) >>> 16;
    mv    = mv + longint'($signed(m_bias));
    if (mv < 0) mv = 0;
    if (mv > 65535) mv = 65535;
    cells = (m_cells == 0) ? 1 : longint'(m_cells);
    v     = (mv <<< FRAC_BITS) / cells;
    if (v > longint'(AVG_MAX)) v = longint'(AVG_MAX);

    if (m_present || v > (longint'(m_thr[LVL_MAXLOW]) <<< FRAC_BITS)) begin
      // detection tick seeds the average with the sample
      if (!m_present) begin
        m_avg     = v;
        m_present = 1'b1;
      end
      m_avg = (10 * m_avg + v + 5) / 11;
      for (int i = 0; i < LEVELS; i++) begin
        if (m_avg < (longint'(m_thr[i]) <<< FRAC_BITS)) begin
          if (m_cnt[i] < PERSIST_TICKS) begin
            m_cnt[i]++;
            if (m_cnt[i] == PERSIST_TICKS && !m_latch[i]) begin
              m_latch[i] = 1'b1;
              fire[i]    = 1'b1;
              if (i == LVL_MAXLOW) m_beeper = 1'b1;
            end
          end
        end else if (m_cnt[i] > 0) begin
          m_cnt[i]--;
        end
      end
    end

    // falling armed clears latches, events of this tick still show
    if (!armed && m_prev_armed) begin
      m_latch  = '0;
      m_beeper = 1'b0;
    end
    m_prev_armed = armed;

    r.avg_cell_mv         = MV_W'(m_avg >>> FRAC_BITS);
    r.low_warn_level      = m_latch[LVL_LOW] ? LOW_LEVEL : '0;
    r.very_low_warn_level = m_latch[LVL_VLOW] ? VLOW_LEVEL : '0;
    r.low_latched         = m_latch[LVL_LOW];
    r.very_low_latched    = m_latch[LVL_VLOW];
    r.max_low_latched     = m_latch[LVL_MAXLOW];
    r.beeper_on           = m_beeper;
    r.low_event           = fire[LVL_LOW];
    r.very_low_event      = fire[LVL_VLOW];
    r.max_low_event       = fire[LVL_MAXLOW];
    return r;
  endfunction

  // converter code that gives roughly this per-cell voltage
  function automatic logic [CODE_W-1:0] code_for(int mv);
    longint num, c;
    if (m_scale == 0) return CODE_W'($urandom);
    num = (longint'(mv) * ((m_cells == 0) ? 1 : longint'(m_cells))
           - longint'($signed(m_bias))) * 65536;
    if (num < 0) num = 0;
    c = num / longint'(m_scale);
    if (c > 4095) c = 4095;
    return CODE_W'(c);
  endfunction

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic stim_row_t item_row(logic [CODE_W-1:0] code, logic armed);
    stim_row_t row;
    row = '{kind: ROW_ITEM, code: code, armed: armed, idx: '0, data: '0,
            typed: 1'b0, want: '0};
    return row;
  endfunction

  function automatic stim_row_t typed_row(logic [CODE_W-1:0] code, logic armed,
                                          alarm_result_t want);
    stim_row_t row;
    row       = item_row(code, armed);
    row.typed = 1'b1;
    row.want  = want;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] data);
    stim_row_t row;
    row      = item_row('0, 1'b0);
    row.kind = ROW_CFG;
    row.idx  = idx;
    row.data = data;
    return row;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("result %0d: %s got %0d, expected %0d", results_seen, what, got, want);
    mismatch_count++;
  endtask

  // leaves cfg_we high; the caller lowers it after the last write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_SCALE:  m_scale = data[SCALE_W-1:0];
      CFG_BIAS:   m_bias  = data[BIAS_W-1:0];
      CFG_CELLS:  m_cells = data[CELLS_W-1:0];
      CFG_LOW:    m_thr[LVL_LOW]    = data[MV_W-1:0];
      CFG_VLOW:   m_thr[LVL_VLOW]   = data[MV_W-1:0];
      CFG_MAXLOW: m_thr[LVL_MAXLOW] = data[MV_W-1:0];
      default: ;
    endcase
  endtask

  task automatic drain_idle();
    if (in_hot) begin
      in_if.valid <= 1'b0;
      in_hot = 1'b0;
    end
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_item(logic [CODE_W-1:0] code, logic armed, bit typed,
                           alarm_result_t want);
    int gap;
    alarm_result_t got;
    gap = pick_gap(src_calm);
    if (gap > 0) begin
      if (in_hot) in_if.valid <= 1'b0;
      in_hot = 1'b0;
      in_if.adc_code  <= CODE_W'($urandom);
      in_if.armed_now <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.adc_code  <= code;
    in_if.armed_now <= armed;
    in_hot = 1'b1;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    got = alarm_step(code, armed);
    pending_results.push_back(typed ? want : got);
  endtask

  task automatic random_config();
    int sel, c, ce, fs, bias, lo, vlo, mlo;
    longint sc;
    drain_idle();
    sel = $urandom_range(0, 9);
    c   = (sel == 0) ? $urandom_range(9, 15) : (sel == 1) ? 0 : $urandom_range(1, 8);
    ce  = (c == 0) ? 1 : c;
    fs  = $urandom_range(4000, 9000);
    sc  = longint'(fs) * ce * 65536 / 4095;
    sel = $urandom_range(0, 19);
    if (sel == 0) sc = 64'hFFFFFF;
    else if (sel == 1) sc = 0;
    sel  = $urandom_range(0, 9);
    bias = (sel == 0) ? -2048 : (sel == 1) ? 2047 : int'($urandom_range(0, 400)) - 200;
    sel  = $urandom_range(0, 9);
    if (sel < 7) begin
      mlo = $urandom_range(2800, 3300);
      vlo = mlo + $urandom_range(0, 300);
      lo  = vlo + $urandom_range(0, 300);
    end else if (sel == 7) begin
      mlo = $urandom_range(0, 8191);
      vlo = $urandom_range(0, 8191);
      lo  = $urandom_range(0, 8191);
    end else if (sel == 8) begin
      mlo = $urandom_range(0, 1) ? 8191 : 0;
      vlo = $urandom_range(0, 1) ? 8191 : 0;
      lo  = $urandom_range(0, 1) ? 8191 : 0;
    end else begin
      // thresholds in reverse order
      lo  = $urandom_range(2800, 3300);
      vlo = lo + $urandom_range(0, 300);
      mlo = vlo + $urandom_range(0, 300);
    end
    write_reg(CFG_CELLS, CFG_DATA_W'(c));
    write_reg(CFG_SCALE, CFG_DATA_W'(sc));
    write_reg(CFG_BIAS, {12'd0, 12'(bias)});
    write_reg(CFG_LOW, CFG_DATA_W'(lo));
    write_reg(CFG_VLOW, CFG_DATA_W'(vlo));
    write_reg(CFG_MAXLOW, CFG_DATA_W'(mlo));
    if ($urandom_range(0, 3) == 0)
      write_reg(CFG_IDX_W'(CFG_SPARE + $urandom_range(0, 1)), CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  // voltage segments around the thresholds, with some raw code noise
  task automatic random_phase(int n);
    int done_n, len, base, mv;
    logic armed;
    done_n = 0;
    armed  = 1'b1;
    while (done_n < n) begin
      src_calm  = ($urandom_range(0, 9) == 0);
      sink_calm = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 9) == 0) begin
        len = $urandom_range(3, 15);
        repeat (len) begin
          send_item(CODE_W'($urandom), 1'($urandom_range(0, 1)), 1'b0, '0);
          done_n++;
        end
      end else begin
        case ($urandom_range(0, 4))
          0: base = int'(m_thr[LVL_LOW]) + int'($urandom_range(50, 800));
          1: base = $urandom_range(m_thr[LVL_LOW], m_thr[LVL_VLOW]);
          2: base = $urandom_range(m_thr[LVL_VLOW], m_thr[LVL_MAXLOW]);
          3: base = int'(m_thr[LVL_MAXLOW]) - int'($urandom_range(50, 500));
          default: base = $urandom_range(0, 8191);
        endcase
        len = $urandom_range(5, 45);
        repeat (len) begin
          mv = base + int'($urandom_range(0, 60)) - 30;
          if ($urandom_range(0, 39) == 0) armed = ~armed;
          send_item(code_for(mv), armed, 1'b0, '0);
          done_n++;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (sink_calm || $urandom_range(0, 99) < 60) begin
      out_if.ready <= 1'b1;
    end else begin
      out_if.ready <= 1'b0;
      stall_left = pick_gap(1'b0);
    end
  end

  always @(posedge clk) begin
    alarm_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_if.avg_cell_mv !== want.avg_cell_mv)
          report_mismatch("avg_cell_mv", out_if.avg_cell_mv, want.avg_cell_mv);
        if (out_if.low_warn_level !== want.low_warn_level)
          report_mismatch("low_warn_level", out_if.low_warn_level, want.low_warn_level);
        if (out_if.very_low_warn_level !== want.very_low_warn_level)
          report_mismatch("very_low_warn_level", out_if.very_low_warn_level,
                          want.very_low_warn_level);
        if (out_if.low_latched !== want.low_latched)
          report_mismatch("low_latched", out_if.low_latched, want.low_latched);
        if (out_if.very_low_latched !== want.very_low_latched)
          report_mismatch("very_low_latched", out_if.very_low_latched,
                          want.very_low_latched);
        if (out_if.max_low_latched !== want.max_low_latched)
          report_mismatch("max_low_latched", out_if.max_low_latched, want.max_low_latched);
        if (out_if.beeper_on !== want.beeper_on)
          report_mismatch("beeper_on", out_if.beeper_on, want.beeper_on);
        if (out_if.low_event !== want.low_event)
          report_mismatch("low_event", out_if.low_event, want.low_event);
        if (out_if.very_low_event !== want.very_low_event)
          report_mismatch("very_low_event", out_if.very_low_event, want.very_low_event);
        if (out_if.max_low_event !== want.max_low_event)
          report_mismatch("max_low_event", out_if.max_low_event, want.max_low_event);
      end
    end
  end

  initial begin
    #3000000;
    $display("timeout, %0d items still expected", pending_results.size());
    $display("Mismatches found");
    $finish;
  end

  initial begin
    alarm_result_t seeded;
    int i;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= '0;
    cfg_wdata       <= '0;
    in_if.valid     <= 1'b0;
    in_if.adc_code  <= '0;
    in_if.armed_now <= 1'b0;
    alarm_reset();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    seeded             = '0;
    seeded.avg_cell_mv = MV_W'(1001);

    // reset values, no battery yet
    stim_table.push_back(typed_row(12'd0, 1'b0, '0));
    stim_table.push_back(item_row(12'd1000, 1'b1));
    // 1 mV per code, one cell: code reads as cell millivolts
    stim_table.push_back(cfg_row(CFG_SCALE, 24'd65536));
    stim_table.push_back(cfg_row(CFG_BIAS, 24'd0));
    stim_table.push_back(cfg_row(CFG_CELLS, 24'd1));
    stim_table.push_back(cfg_row(CFG_LOW, 24'd3000));
    stim_table.push_back(cfg_row(CFG_VLOW, 24'd2000));
    stim_table.push_back(cfg_row(CFG_MAXLOW, 24'd1000));
    stim_table.push_back(cfg_row(CFG_SPARE, 24'hFFFFFF));
    // at the detection level is not detected; disarm with no battery
    stim_table.push_back(typed_row(12'd1000, 1'b0, '0));
    // first sample above it seeds the average
    stim_table.push_back(typed_row(12'd1001, 1'b1, seeded));
    // hold low until low and very low fire
    for (i = 0; i < 19; i++) stim_table.push_back(item_row(12'd0, 1'b1));
    // max low fires on the same tick as disarm
    stim_table.push_back(item_row(12'd0, 1'b0));
    stim_table.push_back(cfg_row(CFG_BIAS, 24'h000800));
    stim_table.push_back(cfg_row(CFG_CELLS, 24'd0));
    stim_table.push_back(item_row(12'd4095, 1'b1));
    stim_table.push_back(cfg_row(CFG_SCALE, 24'hFFFFFF));
    stim_table.push_back(cfg_row(CFG_BIAS, 24'h0007FF));
    stim_table.push_back(cfg_row(CFG_CELLS, 24'd15));
    stim_table.push_back(item_row(12'd4095, 1'b1));

    i = 0;
    while (i < stim_table.size()) begin
      if (stim_table[i].kind == ROW_CFG) begin
        drain_idle();
        while (i < stim_table.size() && stim_table[i].kind == ROW_CFG) begin
          write_reg(stim_table[i].idx, stim_table[i].data);
          i++;
        end
        cfg_we <= 1'b0;
      end else begin
        send_item(stim_table[i].code, stim_table[i].armed, stim_table[i].typed,
                  stim_table[i].want);
        i++;
      end
    end

    for (i = 0; i < RANDOM_PHASES; i++) begin
      random_config();
      random_phase(PHASE_ITEMS);
    end

    drain_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
